@@ hdl/lcdnw_pkg.sv @@
`timescale 1ns / 1ps

package lcdnw_pkg;

	// Operation codes of a request
	localparam logic [2:0] OP_CHAR = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_SDEC = 3'd2;
	localparam logic [2:0] OP_HEX  = 3'd3;
	localparam logic [2:0] OP_BIN  = 3'd4;

	// Bus constants
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] CHR_ZERO     = 8'h30;
	localparam logic [7:0] CHR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHR_PLUS     = 8'h2B;
	localparam logic [7:0] CHR_MINUS    = 8'h2D;

	localparam int MAX_DIGITS = 16;
	localparam int POS_W      = $clog2(MAX_DIGITS);
	localparam int NUM_W      = 16;
	localparam int BCD_W      = 20;

	// Which byte the datapath loads into the output register
	typedef enum logic [1:0] {
		SEL_ADDR,
		SEL_SIGN,
		SEL_CHAR,
		SEL_DIGIT
	} sel_t;

	typedef struct packed {
		logic load;
		logic emit;
		sel_t sel;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       cnt_zero;
		logic       pos_zero;
		logic       conv_busy;
	} dp_status_t;

endpackage

@@ hdl/lcdnw_ctrl.sv @@
`timescale 1ns / 1ps

module lcdnw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  lcdnw_pkg::dp_status_t status,
	output lcdnw_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_SIGN,
		ST_CHAR,
		ST_DIGIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   is_dec;

	assign slot_free = !out_valid_q || out_ready;
	assign is_dec    = (status.op == lcdnw_pkg::OP_UDEC) || (status.op == lcdnw_pkg::OP_SDEC);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.sel  = lcdnw_pkg::SEL_ADDR;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ADDR;
				end
			end
			ST_ADDR: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = lcdnw_pkg::SEL_ADDR;
					if (status.op == lcdnw_pkg::OP_CHAR) begin
						state_d = ST_CHAR;
					end else if (status.op == lcdnw_pkg::OP_SDEC) begin
						state_d = ST_SIGN;
					end else if ((status.op == lcdnw_pkg::OP_UDEC ||
							status.op == lcdnw_pkg::OP_HEX ||
							status.op == lcdnw_pkg::OP_BIN) && !status.cnt_zero) begin
						state_d = ST_DIGIT;
					end else begin
						// unknown operation or no digits: address command ends the run
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = lcdnw_pkg::SEL_SIGN;
					cmd.last = status.cnt_zero;
					state_d  = status.cnt_zero ? ST_IDLE : ST_DIGIT;
				end
			end
			ST_CHAR: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = lcdnw_pkg::SEL_CHAR;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DIGIT: begin
				// decimal digits wait for the BCD shifter to finish
				if (slot_free && !(is_dec && status.conv_busy)) begin
					cmd.emit = 1'b1;
					cmd.sel  = lcdnw_pkg::SEL_DIGIT;
					cmd.last = status.pos_zero;
					if (status.pos_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/lcdnw_dpath.sv @@
`timescale 1ns / 1ps

module lcdnw_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            operation,
	input  logic [1:0]            line,
	input  logic [5:0]            column,
	input  logic [15:0]           number,
	input  logic [4:0]            digit_count,
	input  logic [7:0]            char_code,
	input  lcdnw_pkg::dp_cmd_t    cmd,
	output lcdnw_pkg::dp_status_t status,
	output logic                  is_data,
	output logic [7:0]            bus_byte,
	output logic                  last
);

	localparam int CNT_W = $clog2(lcdnw_pkg::NUM_W + 1);

	logic [2:0]                    op_q;
	logic [1:0]                    line_q;
	logic [5:0]                    column_q;
	logic [7:0]                    char_q;
	logic [lcdnw_pkg::NUM_W-1:0]   val_q;
	logic [lcdnw_pkg::NUM_W-1:0]   sh_q;
	logic [lcdnw_pkg::BCD_W-1:0]   bcd_q;
	logic [lcdnw_pkg::BCD_W-1:0]   bcd_adj;
	logic [CNT_W-1:0]              conv_cnt_q;
	logic [lcdnw_pkg::POS_W-1:0]   pos_q;
	logic                          cnt_zero_q;
	logic                          neg_q;
	logic                          is_data_q;
	logic [7:0]                    bus_byte_q;
	logic                          last_q;

	logic [lcdnw_pkg::NUM_W-1:0]   mag;
	logic [lcdnw_pkg::POS_W-1:0]   pos_init;
	logic                          cnt_zero_init;
	logic [7:0]                    addr_byte;
	logic [3:0]                    digit;
	logic [7:0]                    digit_byte;
	logic [7:0]                    next_byte;

	// magnitude: negate in signed mode; -32768 comes out as 0x8000
	assign mag = (operation == lcdnw_pkg::OP_SDEC && number[15]) ? (~number + 16'd1) : number;

	// clamp the count to MAX_DIGITS, then keep the top position index
	always_comb begin
		if (digit_count >= 5'(lcdnw_pkg::MAX_DIGITS)) begin
			pos_init      = lcdnw_pkg::POS_W'(lcdnw_pkg::MAX_DIGITS - 1);
			cnt_zero_init = 1'b0;
		end else begin
			pos_init      = lcdnw_pkg::POS_W'(digit_count - 5'd1);
			cnt_zero_init = (digit_count == 5'd0);
		end
	end

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < lcdnw_pkg::BCD_W / 4; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
				: bcd_q[i*4 +: 4];
		end
	end

	always_comb begin
		addr_byte = {2'b00, column_q} + 8'hFF;
		if (line_q != 2'd1) begin
			addr_byte = addr_byte + lcdnw_pkg::LINE2_OFFSET;
		end
		addr_byte = addr_byte | lcdnw_pkg::CMD_SET_ADDR;
	end

	always_comb begin
		case (op_q)
			lcdnw_pkg::OP_HEX: begin
				digit = (pos_q < 4) ? 4'(val_q >> {pos_q, 2'b00}) : 4'd0;
			end
			lcdnw_pkg::OP_BIN: begin
				digit = {3'b000, val_q[pos_q]};
			end
			default: begin
				digit = (pos_q < 5) ? 4'(bcd_q >> {pos_q, 2'b00}) : 4'd0;
			end
		endcase
		digit_byte = (digit < 4'd10) ? (lcdnw_pkg::CHR_ZERO + {4'd0, digit})
			: (lcdnw_pkg::CHR_UPPER_A + {4'd0, digit} - 8'd10);
	end

	always_comb begin
		case (cmd.sel)
			lcdnw_pkg::SEL_ADDR:  next_byte = addr_byte;
			lcdnw_pkg::SEL_SIGN:  next_byte = neg_q ? lcdnw_pkg::CHR_MINUS : lcdnw_pkg::CHR_PLUS;
			lcdnw_pkg::SEL_CHAR:  next_byte = char_q;
			default:              next_byte = digit_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_cnt_q <= '0;
		end else if (cmd.load) begin
			conv_cnt_q <= CNT_W'(lcdnw_pkg::NUM_W);
		end else if (conv_cnt_q != '0) begin
			conv_cnt_q <= conv_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= operation;
			line_q     <= line;
			column_q   <= column;
			char_q     <= char_code;
			val_q      <= mag;
			sh_q       <= mag;
			bcd_q      <= '0;
			pos_q      <= pos_init;
			cnt_zero_q <= cnt_zero_init;
			neg_q      <= number[15];
		end else begin
			if (conv_cnt_q != '0) begin
				bcd_q <= {bcd_adj[lcdnw_pkg::BCD_W-2:0], sh_q[lcdnw_pkg::NUM_W-1]};
				sh_q  <= {sh_q[lcdnw_pkg::NUM_W-2:0], 1'b0};
			end
			if (cmd.emit && cmd.sel == lcdnw_pkg::SEL_DIGIT) begin
				pos_q <= pos_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			is_data_q  <= (cmd.sel != lcdnw_pkg::SEL_ADDR);
			bus_byte_q <= next_byte;
			last_q     <= cmd.last;
		end
	end

	assign status.op        = op_q;
	assign status.cnt_zero  = cnt_zero_q;
	assign status.pos_zero  = (pos_q == '0);
	assign status.conv_busy = (conv_cnt_q != '0);

	assign is_data  = is_data_q;
	assign bus_byte = bus_byte_q;
	assign last     = last_q;

endmodule

@@ hdl/character_lcd_number_writer.sv @@
`timescale 1ns / 1ps

// Character-LCD number writer.
// Input channel (in_valid/in_ready): one transaction is one request carrying
// operation, line, column, number, digit_count and char_code.
// Output channel (out_valid/out_ready): one transaction is one LCD bus write
// (is_data, bus_byte, last). A request yields a set-address command, then
// either one character, an optional sign and 0..16 digits, or nothing more
// for an unknown operation; last marks the final write of the run.
// The address command is sent from the ADDR state after acceptance, through
// the output register. Decimal digits come from a 16-step binary-to-BCD
// shifter started at acceptance; the digit state waits until it is done. One
// request is in work at a time: in_ready rises once the last write is loaded
// into the output register, so the next request is taken while that write
// still waits.
// Reset clears the controller and the output valid; no writes are pending.
// A stalled receiver holds the output register and freezes the run.

module character_lcd_number_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [1:0]  line,
	input  logic [5:0]  column,
	input  logic [15:0] number,
	input  logic [4:0]  digit_count,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_data,
	output logic [7:0]  bus_byte,
	output logic        last
);

	lcdnw_pkg::dp_cmd_t    cmd;
	lcdnw_pkg::dp_status_t status;

	// sequence the run: address, sign or char, digits
	lcdnw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the request, convert to BCD, build each bus byte
	lcdnw_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.line        (line),
		.column      (column),
		.number      (number),
		.digit_count (digit_count),
		.char_code   (char_code),
		.cmd         (cmd),
		.status      (status),
		.is_data     (is_data),
		.bus_byte    (bus_byte),
		.last        (last)
	);

	// a request in work blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while previous run active");

	// a write that is not the last of its run means the run is still going
	a_mid_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("idle with an unfinished run");

	// every command write is a set-address command
	a_cmd_is_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_data) |-> bus_byte[7])
		else $error("command write without set-address bit");

endmodule
